[sv/dws_pkg.sv]
// Package with widths, time constants and register indexes of the daily window scheduler.
`default_nettype none

package dws_pkg;

    // Field widths
    localparam int HourW   = 5;
    localparam int MinW    = 6;
    localparam int SecW    = 6;
    localparam int DayW    = 5;
    localparam int MinDayW = 11;
    localparam int AddrW   = 5;
    localparam int DataW   = 32;

    // Time constants
    localparam int MinPerDay  = 1440;
    localparam int MinPerHour = 60;
    localparam int HourPerDay = 24;
    localparam int PurgeHour  = 12;

    typedef logic [HourW-1:0]   t_hour;
    typedef logic [MinW-1:0]    t_minute;
    typedef logic [SecW-1:0]    t_second;
    typedef logic [DayW-1:0]    t_day;
    typedef logic [MinDayW-1:0] t_min_of_day;

    // Register indexes, one word apart on the configuration port
    typedef enum logic [2:0] {
        REG_FILTER1_START  = 3'd0,
        REG_FILTER1_LENGTH = 3'd1,
        REG_FILTER2_START  = 3'd2,
        REG_FILTER2_LENGTH = 3'd3,
        REG_ECO_START_HOUR = 3'd4,
        REG_ECO_STOP_HOUR  = 3'd5,
        REG_ENABLE_MASK    = 3'd6,
        REG_PURGE_TICKS    = 3'd7
    } t_reg_idx;

endpackage

`default_nettype wire

[sv/dws_if.sv]
// Stream interfaces for the input ticks and the result items of the scheduler.
`default_nettype none

interface dws_in_if import dws_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  time_valid;
    t_hour   clock_hour;
    t_minute clock_minute;
    t_second clock_second;
    t_day    day_of_month;

    modport source (output valid, time_valid, clock_hour, clock_minute, clock_second,
                    day_of_month, input ready);
    modport sink (input valid, time_valid, clock_hour, clock_minute, clock_second,
                  day_of_month, output ready);
endinterface

interface dws_out_if import dws_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    filter_on;
    logic    heat_allowed;
    logic    purge_on;
    logic    synced;
    t_hour   held_hour;
    t_minute held_minute;
    t_second held_second;

    modport source (output valid, filter_on, heat_allowed, purge_on, synced, held_hour,
                    held_minute, held_second, input ready);
    modport sink (input valid, filter_on, heat_allowed, purge_on, synced, held_hour,
                  held_minute, held_second, output ready);
endinterface

`default_nettype wire

[sv/dws_window.sv]
// Time-of-day window test with length saturation and wrap past midnight.
`default_nettype none

module dws_window import dws_pkg::*; (
    input  t_min_of_day i_start,
    input  t_min_of_day i_length,
    input  t_min_of_day i_now,
    output logic        o_hit
);

    localparam logic [MinDayW:0] DayMin  = (MinDayW+1)'(MinPerDay);
    localparam logic [MinDayW:0] TwoDays = (MinDayW+1)'(2 * MinPerDay);

    logic [MinDayW:0] w_len_sat;
    logic [MinDayW:0] w_stop;
    logic [MinDayW:0] w_wrap;
    logic [MinDayW:0] w_now;
    logic [MinDayW:0] w_start;

    // Clamp length to one day, then find the end point
    always_comb begin
        w_now     = {1'b0, i_now};
        w_start   = {1'b0, i_start};
        w_len_sat = ({1'b0, i_length} > DayMin) ? DayMin : {1'b0, i_length};
        w_stop    = w_start + w_len_sat;
        // End point folded back into the day (below three days, two subtracts suffice)
        w_wrap    = (w_stop >= TwoDays) ? (w_stop - TwoDays) : (w_stop - DayMin);
        if (w_stop <= DayMin) begin
            o_hit = (w_now >= w_start) && (w_now < w_stop);
        end else begin
            o_hit = (w_now >= w_start) || (w_now < w_wrap);
        end
    end

endmodule

`default_nettype wire

[sv/daily_window_scheduler_top.sv]
// Top level of the daily window scheduler: config registers, tick pipeline and result register.
`default_nettype none

// Takes one clock tick item per cycle unless the result side stalls, and returns one result
// per item once the output side is free: the tick is captured in an input
// register, then a single pass of logic updates the held time and purge timer,
// evaluates both filter windows and the economy window, and loads the result
// register. Sustained rate is one item per cycle, set by that single-pass stage;
// a stall on the result side holds the input register while one item still waits.
// Registers sit at byte address 4*index on the APB-style port; write them only idle.

module daily_window_scheduler_top import dws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dws_in_if.sink           i_in,
    dws_out_if.source        o_out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    localparam logic [7:0] ElapsedMax = 8'hFF;

    // Configuration registers
    t_min_of_day r_f1_start, r_f1_length, r_f2_start, r_f2_length;
    t_hour       r_eco_start, r_eco_stop;
    logic [2:0]  r_enable;
    logic [7:0]  r_purge_ticks;

    t_reg_idx    w_idx;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[AddrW-1:2]);
    assign w_cfg_wr = psel && penable && pwrite;

    // Write a register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_start    <= '0;
            r_f1_length   <= '0;
            r_f2_start    <= '0;
            r_f2_length   <= '0;
            r_eco_start   <= '0;
            r_eco_stop    <= '0;
            r_enable      <= '0;
            r_purge_ticks <= 8'd30;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_FILTER1_START:  r_f1_start    <= pwdata[MinDayW-1:0];
                REG_FILTER1_LENGTH: r_f1_length   <= pwdata[MinDayW-1:0];
                REG_FILTER2_START:  r_f2_start    <= pwdata[MinDayW-1:0];
                REG_FILTER2_LENGTH: r_f2_length   <= pwdata[MinDayW-1:0];
                REG_ECO_START_HOUR: r_eco_start   <= pwdata[HourW-1:0];
                REG_ECO_STOP_HOUR:  r_eco_stop    <= pwdata[HourW-1:0];
                REG_ENABLE_MASK:    r_enable      <= pwdata[2:0];
                REG_PURGE_TICKS:    r_purge_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            REG_FILTER1_START:  prdata = DataW'(r_f1_start);
            REG_FILTER1_LENGTH: prdata = DataW'(r_f1_length);
            REG_FILTER2_START:  prdata = DataW'(r_f2_start);
            REG_FILTER2_LENGTH: prdata = DataW'(r_f2_length);
            REG_ECO_START_HOUR: prdata = DataW'(r_eco_start);
            REG_ECO_STOP_HOUR:  prdata = DataW'(r_eco_stop);
            REG_ENABLE_MASK:    prdata = DataW'(r_enable);
            REG_PURGE_TICKS:    prdata = DataW'(r_purge_ticks);
            default:            prdata = '0;
        endcase
    end

    // Pipeline flow control
    logic    r_s1_valid;
    logic    r_s1_tv;
    t_hour   r_s1_hour;
    t_minute r_s1_minute;
    t_second r_s1_second;
    t_day    r_s1_day;
    logic    r_out_valid;
    logic    w_adv;
    logic    w_take;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_take     = r_s1_valid && w_adv;
    assign i_in.ready = !r_s1_valid || w_adv;

    // Capture the tick on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_tv     <= i_in.time_valid;
            r_s1_hour   <= i_in.clock_hour;
            r_s1_minute <= i_in.clock_minute;
            r_s1_second <= i_in.clock_second;
            r_s1_day    <= i_in.day_of_month;
        end
    end

    // Scheduler state
    logic       r_sync;
    t_hour      r_hour;
    t_minute    r_minute;
    t_second    r_second;
    logic       r_purge;
    logic [7:0] r_elapsed;
    logic [7:0] r_last_day;

    logic        n_sync;
    t_hour       n_hour;
    t_minute     n_minute;
    t_second     n_second;
    logic        n_purge;
    logic [7:0]  n_elapsed;
    logic [7:0]  n_last_day;
    logic        w_start;
    t_min_of_day w_now;

    // Hold or load the time, run the purge timer
    always_comb begin
        n_sync     = r_sync | r_s1_tv;
        n_hour     = r_s1_tv ? r_s1_hour   : r_hour;
        n_minute   = r_s1_tv ? r_s1_minute : r_minute;
        n_second   = r_s1_tv ? r_s1_second : r_second;
        w_start    = r_s1_tv && (r_s1_hour == HourW'(PurgeHour)) && (r_s1_minute == '0)
                     && ({3'b000, r_s1_day} != r_last_day) && !r_purge;
        n_purge    = r_purge | w_start;
        n_elapsed  = w_start ? 8'd0 : r_elapsed;
        n_last_day = w_start ? {3'b000, r_s1_day} : r_last_day;
        if (n_purge) begin
            if (!w_start && (r_elapsed < ElapsedMax)) begin
                n_elapsed = r_elapsed + 8'd1;
            end
            if (n_elapsed >= r_purge_ticks) begin
                n_purge = 1'b0;
            end
        end
        w_now = MinDayW'(n_hour * MinDayW'(MinPerHour)) + MinDayW'(n_minute);
    end

    // Economy window bounds in minutes
    t_min_of_day w_eco_start_min;
    t_min_of_day w_eco_len;
    logic [5:0]  w_eco_span;

    always_comb begin
        w_eco_start_min = MinDayW'(r_eco_start * MinDayW'(MinPerHour));
        if (r_eco_stop >= r_eco_start) begin
            w_eco_span = 6'(r_eco_stop - r_eco_start);
        end else if ((6'(HourPerDay) + 6'(r_eco_stop)) >= 6'(r_eco_start)) begin
            w_eco_span = 6'(HourPerDay) + 6'(r_eco_stop) - 6'(r_eco_start);
        end else begin
            w_eco_span = '0;
        end
        w_eco_len = MinDayW'(w_eco_span * 12'(MinPerHour));
    end

    logic w_f1_hit, w_f2_hit, w_eco_hit;
    logic w_filter, w_heat;

    dws_window u_win_f1 (
        .i_start  (r_f1_start),
        .i_length (r_f1_length),
        .i_now    (w_now),
        .o_hit    (w_f1_hit)
    );

    dws_window u_win_f2 (
        .i_start  (r_f2_start),
        .i_length (r_f2_length),
        .i_now    (w_now),
        .o_hit    (w_f2_hit)
    );

    dws_window u_win_eco (
        .i_start  (w_eco_start_min),
        .i_length (w_eco_len),
        .i_now    (w_now),
        .o_hit    (w_eco_hit)
    );

    // Combine window hits under the enables
    assign w_filter = (r_enable[0] && w_f1_hit) || (r_enable[1] && w_f2_hit);
    assign w_heat   = r_enable[2] ? (w_eco_hit || w_filter) : 1'b1;

    // Advance the state once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= 1'b0;
            r_hour     <= HourW'(PurgeHour);
            r_minute   <= '0;
            r_second   <= '0;
            r_purge    <= 1'b0;
            r_elapsed  <= '0;
            r_last_day <= 8'hFF;
        end else if (w_take) begin
            r_sync     <= n_sync;
            r_hour     <= n_hour;
            r_minute   <= n_minute;
            r_second   <= n_second;
            r_purge    <= n_purge;
            r_elapsed  <= n_elapsed;
            r_last_day <= n_last_day;
        end
    end

    // Result register
    logic    r_o_filter, r_o_heat, r_o_purge, r_o_sync;
    t_hour   r_o_hour;
    t_minute r_o_minute;
    t_second r_o_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_o_filter <= w_filter;
            r_o_heat   <= w_heat;
            r_o_purge  <= n_purge;
            r_o_sync   <= n_sync;
            r_o_hour   <= n_hour;
            r_o_minute <= n_minute;
            r_o_second <= n_second;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.filter_on    = r_o_filter;
    assign o_out.heat_allowed = r_o_heat;
    assign o_out.purge_on     = r_o_purge;
    assign o_out.synced       = r_o_sync;
    assign o_out.held_hour    = r_o_hour;
    assign o_out.held_minute  = r_o_minute;
    assign o_out.held_second  = r_o_second;

endmodule

`default_nettype wire
